[rtl/separated_sorted_level_table_unit_macros.svh]
// Assertion macros used by the level table RTL.
`ifndef SEPARATED_SORTED_LEVEL_TABLE_UNIT_MACROS_SVH
`define SEPARATED_SORTED_LEVEL_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sslt_pkg.sv]
`default_nettype none
package sslt_pkg;
	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_REM_VAL  = 3'd1,
		OP_REM_RNG  = 3'd2,
		OP_READ     = 3'd3,
		OP_GAP      = 3'd4,
		OP_BUCKET   = 3'd5,
		OP_SPACING  = 3'd6,
		OP_CLEAR    = 3'd7
	} op_t;

	typedef enum logic {
		REG_SEPARATION = 1'b0,
		REG_TOLERANCE  = 1'b1
	} reg_t;

	localparam logic signed [30:0] SENTINEL   = 31'sd1000000000;
	localparam logic signed [30:0] S31_MAX    = 31'sh3FFFFFFF;
	localparam logic signed [30:0] S31_MIN    = 31'sh40000000;
	localparam logic signed [30:0] NO_SPACING = 31'sh7FFFFFFF;
	localparam logic [16:0] SEP_RESET = 17'd500;
	localparam logic [9:0]  TOL_RESET = 10'd1;
endpackage
`default_nettype wire

[rtl/separated_sorted_level_table_unit.sv]
// Level table: one item at a time, held in a single-port-read, single-port-write memory.
// Each memory read issues the address and then uses the registered data. Scans read the entries
// one at a time; an insert rescans from the bottom after each nudge and then shifts the entries
// above its place up one by one, and spacing compares all pairs of entries.
// A new item is taken only when the previous one has reached the output register.
// Reset empties the table and loads separation 500 mm and tolerance 1 mm; memory is not cleared.
`default_nettype none
`include "separated_sorted_level_table_unit_macros.svh"
module separated_sorted_level_table_unit #(
	parameter int MAX_LEVELS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         operation,
	input  wire logic signed [30:0] value,
	input  wire logic [6:0]         index,
	input  wire logic [6:0]         count,
	input  wire logic               keep_apart,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    ok,
	output logic signed [30:0]      first_value,
	output logic signed [30:0]      second_value,
	output logic [6:0]              position
);
	localparam int AW = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
	localparam int CW = $clog2(MAX_LEVELS + 1);
	localparam int XW = (CW > 8) ? CW + 1 : 9;
	localparam int NW = $clog2(2 * MAX_LEVELS + 2);

	typedef enum logic [4:0] {
		ST_IDLE, ST_INS_RD, ST_INS_CHK, ST_EQ_RD, ST_EQ_CHK, ST_UP_RD, ST_UP_WR,
		ST_RV_RD, ST_RV_CHK, ST_DN_RD, ST_DN_WR, ST_RD_ISS, ST_RD_USE,
		ST_GAP_A, ST_GAP_B, ST_GAP_C, ST_BK_RD, ST_BK_CHK,
		ST_SP_RDI, ST_SP_LDI, ST_SP_RDJ, ST_SP_USE, ST_DONE
	} state_t;

	state_t state_q;
	logic [16:0] sep_q;
	logic [9:0]  tol_q;
	logic [CW-1:0] count_q;
	logic signed [30:0] v_q, a_q;
	logic [XW-1:0] idx_q, n_q, i_q, j_q, p_q;
	logic [NW-1:0] nud_q;
	logic res_ok_q, bucket_q;
	logic signed [30:0] res_first_q, res_second_q;
	logic [XW-1:0] res_pos_q;

	logic signed [30:0] mem [MAX_LEVELS];
	logic signed [30:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic signed [30:0] wdata;
	logic we;

	logic [XW-1:0] cnt_x;
	logic signed [32:0] v33, lv33, sep33, tol33, a33, diff33, absd33;
	logic signed [30:0] pair_dist;
	sslt_pkg::op_t op_in;
	logic sp_few;

	function automatic logic signed [30:0] sat31(input logic signed [32:0] x);
		logic signed [32:0] lo, hi;
		lo = {{2{sslt_pkg::S31_MIN[30]}}, sslt_pkg::S31_MIN};
		hi = {{2{sslt_pkg::S31_MAX[30]}}, sslt_pkg::S31_MAX};
		if (x < lo) return sslt_pkg::S31_MIN;
		if (x > hi) return sslt_pkg::S31_MAX;
		return x[30:0];
	endfunction

	assign pready = 1'b1;
	always_comb begin
		unique case (sslt_pkg::reg_t'(paddr[2]))
			sslt_pkg::REG_SEPARATION: prdata = {15'd0, sep_q};
			sslt_pkg::REG_TOLERANCE:  prdata = {22'd0, tol_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= sslt_pkg::SEP_RESET;
			tol_q <= sslt_pkg::TOL_RESET;
		end else if (psel && penable && pwrite) begin
			if (sslt_pkg::reg_t'(paddr[2]) == sslt_pkg::REG_SEPARATION) begin
				sep_q <= pwdata[16:0];
			end else begin
				tol_q <= pwdata[9:0];
			end
		end
	end

	assign cnt_x  = XW'(count_q);
	assign v33    = {{2{v_q[30]}}, v_q};
	assign lv33   = {{2{rdata_q[30]}}, rdata_q};
	assign a33    = {{2{a_q[30]}}, a_q};
	assign sep33  = $signed({16'd0, sep_q});
	assign tol33  = $signed({23'd0, tol_q});
	assign diff33 = lv33 - a33;
	assign absd33 = diff33[32] ? -diff33 : diff33;
	assign pair_dist = (absd33 > {{2{1'b0}}, sslt_pkg::S31_MAX}) ? sslt_pkg::S31_MAX
		: absd33[30:0];
	assign op_in  = sslt_pkg::op_t'(operation);
	assign sp_few = (cnt_x < XW'(2));

	assign in_ready = (state_q == ST_IDLE);

	// Read address and write port follow the sequencer state.
	always_comb begin
		raddr = i_q[AW-1:0];
		waddr = i_q[AW-1:0];
		wdata = rdata_q;
		we    = 1'b0;
		unique case (state_q)
			ST_EQ_RD:  raddr = j_q[AW-1:0];
			ST_UP_RD: begin
				raddr = AW'(i_q - XW'(1));
				if (i_q <= p_q) begin
					we    = 1'b1;
					waddr = p_q[AW-1:0];
					wdata = v_q;
				end
			end
			ST_UP_WR:  we = 1'b1;
			ST_DN_RD:  raddr = AW'(i_q + n_q);
			ST_DN_WR:  we = 1'b1;
			ST_RD_ISS: raddr = idx_q[AW-1:0];
			ST_GAP_A:  raddr = AW'(idx_q - XW'(1));
			ST_GAP_B:  raddr = idx_q[AW-1:0];
			ST_SP_RDJ: raddr = j_q[AW-1:0];
			default:   raddr = i_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			// The completion state reloads the output register itself.
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q          <= value;
						idx_q        <= XW'(index);
						res_ok_q     <= (op_in == sslt_pkg::OP_CLEAR);
						res_first_q  <= (op_in == sslt_pkg::OP_SPACING && sp_few)
							? sslt_pkg::NO_SPACING : '0;
						res_second_q <= (op_in != sslt_pkg::OP_SPACING) ? '0
							: (sp_few ? sslt_pkg::NO_SPACING : sslt_pkg::S31_MAX);
						bucket_q     <= (op_in == sslt_pkg::OP_BUCKET);
						i_q          <= (op_in == sslt_pkg::OP_REM_RNG) ? XW'(index) : '0;
						j_q          <= '0;
						nud_q        <= '0;
						unique case (op_in)
							sslt_pkg::OP_INSERT: begin
								if (cnt_x >= XW'(MAX_LEVELS)) begin
									state_q <= ST_DONE;
								end else if (keep_apart) begin
									state_q <= ST_INS_RD;
								end else begin
									p_q     <= cnt_x;
									state_q <= ST_EQ_RD;
								end
							end
							sslt_pkg::OP_REM_VAL: state_q <= ST_RV_RD;
							sslt_pkg::OP_REM_RNG: begin
								if (XW'(index) + XW'(count) <= cnt_x) begin
									n_q     <= XW'(count);
									state_q <= ST_DN_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							sslt_pkg::OP_READ: begin
								state_q <= (XW'(index) < cnt_x) ? ST_RD_ISS : ST_DONE;
							end
							sslt_pkg::OP_GAP: begin
								state_q <= (XW'(index) <= cnt_x) ? ST_GAP_A : ST_DONE;
							end
							sslt_pkg::OP_BUCKET: state_q <= ST_BK_RD;
							sslt_pkg::OP_SPACING: begin
								state_q <= sp_few ? ST_DONE : ST_SP_RDI;
							end
							sslt_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_INS_RD: begin
					if (i_q >= cnt_x) begin
						p_q     <= i_q;
						j_q     <= '0;
						state_q <= ST_EQ_RD;
					end else begin
						state_q <= ST_INS_CHK;
					end
				end
				ST_INS_CHK: begin
					if ((v33 < lv33 && v33 > lv33 - sep33) || (v33 < lv33 + sep33 && v33 >= lv33)) begin
						// Nudge away from this level and rescan from the bottom.
						v_q <= (v33 < lv33) ? sat31(lv33 - sep33) : sat31(lv33 + sep33);
						if (nud_q == NW'(2 * MAX_LEVELS)) begin
							state_q <= ST_DONE;
						end else begin
							nud_q   <= nud_q + NW'(1);
							i_q     <= '0;
							state_q <= ST_INS_RD;
						end
					end else if (v33 < lv33 + sep33) begin
						p_q     <= i_q;
						j_q     <= '0;
						state_q <= ST_EQ_RD;
					end else begin
						i_q     <= i_q + XW'(1);
						state_q <= ST_INS_RD;
					end
				end
				ST_EQ_RD: begin
					if (j_q >= cnt_x) begin
						i_q     <= cnt_x;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_EQ_CHK;
					end
				end
				ST_EQ_CHK: begin
					if (rdata_q == v_q) begin
						state_q <= ST_DONE;
					end else begin
						j_q     <= j_q + XW'(1);
						state_q <= ST_EQ_RD;
					end
				end
				ST_UP_RD: begin
					if (i_q <= p_q) begin
						count_q  <= count_q + CW'(1);
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_UP_WR;
					end
				end
				ST_UP_WR: begin
					i_q     <= i_q - XW'(1);
					state_q <= ST_UP_RD;
				end
				ST_RV_RD: begin
					state_q <= (i_q >= cnt_x) ? ST_DONE : ST_RV_CHK;
				end
				ST_RV_CHK: begin
					if (v33 < lv33 + tol33 && v33 > lv33 - tol33) begin
						n_q     <= XW'(1);
						state_q <= ST_DN_RD;
					end else begin
						i_q     <= i_q + XW'(1);
						state_q <= ST_RV_RD;
					end
				end
				ST_DN_RD: begin
					if (i_q + n_q < cnt_x) begin
						state_q <= ST_DN_WR;
					end else begin
						count_q  <= CW'(cnt_x - n_q);
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DN_WR: begin
					i_q     <= i_q + XW'(1);
					state_q <= ST_DN_RD;
				end
				ST_RD_ISS: state_q <= ST_RD_USE;
				ST_RD_USE: begin
					res_first_q <= rdata_q;
					res_ok_q    <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_GAP_A: state_q <= ST_GAP_B;
				ST_GAP_B: begin
					res_first_q <= (idx_q == '0) ? -sslt_pkg::SENTINEL : rdata_q;
					state_q     <= ST_GAP_C;
				end
				ST_GAP_C: begin
					res_second_q <= (idx_q == cnt_x) ? sslt_pkg::SENTINEL : rdata_q;
					res_ok_q     <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_BK_RD: begin
					if (i_q >= cnt_x) begin
						res_pos_q <= i_q + XW'(1);
						res_ok_q  <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_BK_CHK;
					end
				end
				ST_BK_CHK: begin
					if (v33 < lv33) begin
						res_pos_q <= i_q + XW'(1);
						res_ok_q  <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						i_q     <= i_q + XW'(1);
						state_q <= ST_BK_RD;
					end
				end
				ST_SP_RDI: state_q <= ST_SP_LDI;
				ST_SP_LDI: begin
					a_q     <= rdata_q;
					j_q     <= i_q + XW'(1);
					state_q <= ST_SP_RDJ;
				end
				ST_SP_RDJ: state_q <= ST_SP_USE;
				ST_SP_USE: begin
					if (pair_dist > res_first_q) begin
						res_first_q <= pair_dist;
					end
					if (pair_dist < res_second_q) begin
						res_second_q <= pair_dist;
					end
					if (j_q + XW'(1) < cnt_x) begin
						j_q     <= j_q + XW'(1);
						state_q <= ST_SP_RDJ;
					end else if (i_q + XW'(2) < cnt_x) begin
						i_q     <= i_q + XW'(1);
						state_q <= ST_SP_RDI;
					end else begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						ok           <= res_ok_q;
						first_value  <= res_first_q;
						second_value <= res_second_q;
						position     <= bucket_q ? res_pos_q[6:0] : cnt_x[6:0];
						out_valid    <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SSLT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, cnt_x <= XW'(MAX_LEVELS), "entry count beyond capacity")
	`SSLT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "second item taken while one is in work")
	`SSLT_ASSERT_NOW(a_result_from_done, clk, arst_n, $rose(out_valid), $past(state_q) == ST_DONE, "result appeared outside completion")
	`SSLT_ASSERT_NOW(a_write_idle, clk, arst_n, state_q == ST_IDLE, !we, "memory written while idle")
endmodule
`default_nettype wire

[tb/sslt_level_checker.sv]
`default_nettype none
module sslt_level_checker
	import sslt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [2:0]         operation,
	input  wire logic signed [30:0] value,
	input  wire logic [6:0]         index,
	input  wire logic [6:0]         count,
	input  wire logic               keep_apart,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               ok,
	input  wire logic signed [30:0] first_value,
	input  wire logic signed [30:0] second_value,
	input  wire logic [6:0]         position,
	output int                      mismatches,
	output int                      pending,
	output int                      checked,
	output int                      table_size
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam longint TOP31 = 64'sd1073741823;
	localparam longint BOTTOM31 = -64'sd1073741824;
	localparam longint GAP_EDGE = 64'sd1000000000;

	typedef struct packed {
		logic               ok;
		logic signed [30:0] first_value;
		logic signed [30:0] second_value;
		logic [6:0]         position;
	} level_result_t;

	longint        levels [DEPTH];
	int            n_levels;
	longint        sep_mm;
	longint        tol_mm;
	level_result_t expected_results [$];

	function automatic longint clamp31(longint x);
		if (x < BOTTOM31)
			return BOTTOM31;
		if (x > TOP31)
			return TOP31;
		return x;
	endfunction

	function automatic void drop_levels(int at, int num);
		for (int k = at; k + num < n_levels; k++)
			levels[k] = levels[k + num];
		n_levels -= num;
	endfunction

	function automatic bit place_level(longint v, bit apart);
		int i;
		int nudges;
		longint lv;
		i = 0;
		nudges = 0;
		if (n_levels >= DEPTH)
			return 0;
		if (apart) begin
			while (i < n_levels) begin
				lv = levels[i];
				if (v < lv && v > lv - sep_mm)
					v = clamp31(lv - sep_mm);
				else if (v < lv + sep_mm && v >= lv)
					v = clamp31(lv + sep_mm);
				else if (v < lv + sep_mm)
					break;
				else begin
					i++;
					continue;
				end
				nudges++;
				// A value caught between two close levels bounces for ever.
				if (nudges > 2 * DEPTH)
					return 0;
				i = 0;
			end
		end else begin
			i = n_levels;
		end
		for (int k = 0; k < n_levels; k++)
			if (levels[k] == v)
				return 0;
		for (int k = n_levels; k > i; k--)
			levels[k] = levels[k - 1];
		levels[i] = v;
		n_levels++;
		return 1;
	endfunction

	function automatic level_result_t apply_level_op(op_t op, longint v, int idx, int cnt,
			bit apart);
		level_result_t r;
		longint lo, hi, d;
		bit is_bucket;
		int i;
		r = '0;
		lo = 0;
		hi = 0;
		is_bucket = 0;
		case (op)
			OP_INSERT: r.ok = place_level(v, apart);
			OP_REM_VAL: begin
				for (i = 0; i < n_levels; i++)
					if (v < levels[i] + tol_mm && v > levels[i] - tol_mm) begin
						drop_levels(i, 1);
						r.ok = 1;
						break;
					end
			end
			OP_REM_RNG: begin
				if (idx + cnt <= n_levels) begin
					drop_levels(idx, cnt);
					r.ok = 1;
				end
			end
			OP_READ: begin
				if (idx < n_levels) begin
					lo = levels[idx];
					r.ok = 1;
				end
			end
			OP_GAP: begin
				if (idx <= n_levels) begin
					lo = (idx == 0) ? -GAP_EDGE : levels[idx - 1];
					hi = (idx == n_levels) ? GAP_EDGE : levels[idx];
					r.ok = 1;
				end
			end
			OP_BUCKET: begin
				for (i = 0; i < n_levels; i++)
					if (v < levels[i])
						break;
				r.position = 7'(i + 1);
				is_bucket = 1;
				r.ok = 1;
			end
			OP_SPACING: begin
				if (n_levels >= 2) begin
					lo = 0;
					hi = TOP31;
					for (int a = 0; a + 1 < n_levels; a++)
						for (int b = a + 1; b < n_levels; b++) begin
							d = levels[b] - levels[a];
							if (d < 0)
								d = -d;
							if (d > TOP31)
								d = TOP31;
							if (d > lo)
								lo = d;
							if (d < hi)
								hi = d;
						end
					r.ok = 1;
				end else begin
					lo = -1;
					hi = -1;
				end
			end
			default: begin
				n_levels = 0;
				r.ok = 1;
			end
		endcase
		r.first_value = lo[30:0];
		r.second_value = hi[30:0];
		if (!is_bucket)
			r.position = 7'(n_levels);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		level_result_t want;
		level_result_t got;
		if (!arst_n) begin
			n_levels = 0;
			sep_mm = longint'(SEP_RESET);
			tol_mm = longint'(TOL_RESET);
			expected_results.delete();
			mismatches = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (reg_t'(paddr[2]) == REG_SEPARATION)
					sep_mm = longint'(pwdata[16:0]);
				else
					tol_mm = longint'(pwdata[9:0]);
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_level_op(op_t'(operation),
					longint'(value), int'(index), int'(count), keep_apart));
			if (out_valid && out_ready) begin
				got = {ok, first_value, second_value, position};
				checked++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: result item with nothing expected", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: expected ok=%0d first=%0d second=%0d pos=%0d, got ok=%0d first=%0d second=%0d pos=%0d",
								$realtime, want.ok, want.first_value, want.second_value,
								want.position, got.ok, got.first_value,
								got.second_value, got.position);
					end
				end
			end
		end
		pending = expected_results.size();
		table_size = n_levels;
	end
endmodule
`default_nettype wire

[tb/tb_separated_sorted_level_table_unit.sv]
`default_nettype none
module tb_separated_sorted_level_table_unit;
	import sslt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 300000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         operation;
	logic signed [30:0] value;
	logic [6:0]         index;
	logic [6:0]         count;
	logic               keep_apart;
	logic               out_valid;
	logic               out_ready;
	logic               ok;
	logic signed [30:0] first_value;
	logic signed [30:0] second_value;
	logic [6:0]         position;

	int mismatches;
	int pending;
	int checked;
	int table_size;
	int items_sent;
	int burst_left;
	int ready_mode;
	int ready_left;
	int idle_cycles;

	separated_sorted_level_table_unit i_dut (.*);

	sslt_level_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: phases of always ready, coin-flip ready and long stalls.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_left <= $urandom_range(20, 300);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	task automatic write_reg(reg_t which, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The task first waits for the clock so that the checker has counted the last item taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_limits(int sep, int tol);
		drain_results();
		write_reg(REG_SEPARATION, 32'(sep));
		write_reg(REG_TOLERANCE, 32'(tol));
	endtask

	task automatic send_level_op(op_t op, logic signed [30:0] v, int idx, int cnt,
			bit apart);
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		index <= 7'(idx);
		count <= 7'(cnt);
		keep_apart <= apart;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_op();
		int pick;
		op_t op;
		logic signed [30:0] v;
		int idx;
		int cnt;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_INSERT;
		else if (pick < 52)
			op = OP_REM_VAL;
		else if (pick < 62)
			op = OP_REM_RNG;
		else if (pick < 72)
			op = OP_READ;
		else if (pick < 80)
			op = OP_GAP;
		else if (pick < 88)
			op = OP_BUCKET;
		else if (pick < 94)
			op = OP_SPACING;
		else
			op = OP_CLEAR;
		if ($urandom_range(0, 9) < 7)
			v = 31'(int'($urandom_range(0, 40000)) - 20000);
		else
			v = 31'($urandom);
		idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, table_size + 1)
			: $urandom_range(0, 127);
		cnt = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 127);
		send_level_op(op, v, idx, cnt, $urandom_range(0, 3) != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = OP_CLEAR;
		value = '0;
		index = '0;
		count = '0;
		keep_apart = 1'b0;
		out_ready = 1'b0;
		ready_mode = 0;
		ready_left = 0;
		items_sent = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset separation of 500 mm.
		send_level_op(OP_CLEAR, 0, 0, 0, 0);
		send_level_op(OP_INSERT, 0, 0, 0, 0);
		send_level_op(OP_INSERT, 600, 0, 0, 0);
		send_level_op(OP_INSERT, 600, 0, 0, 0);
		// Levels 0 and 600 are too close for 300 to settle: it bounces.
		send_level_op(OP_INSERT, 300, 0, 0, 1);
		send_level_op(OP_INSERT, S31_MAX, 0, 0, 1);
		// Just below the stored maximum, it is nudged to one separation below that maximum.
		send_level_op(OP_INSERT, 31'sh3FFFFF00, 0, 0, 1);
		send_level_op(OP_INSERT, S31_MIN, 0, 0, 1);
		send_level_op(OP_READ, 0, 0, 0, 0);
		send_level_op(OP_READ, 0, 127, 0, 0);
		send_level_op(OP_GAP, 0, 0, 0, 0);
		send_level_op(OP_GAP, 0, 4, 0, 0);
		send_level_op(OP_GAP, 0, 127, 0, 0);
		send_level_op(OP_BUCKET, S31_MIN, 0, 0, 0);
		send_level_op(OP_BUCKET, S31_MAX, 0, 0, 0);
		send_level_op(OP_SPACING, 0, 0, 0, 0);
		send_level_op(OP_REM_VAL, 600, 0, 0, 0);
		send_level_op(OP_REM_VAL, 12345, 0, 0, 0);
		send_level_op(OP_REM_RNG, 0, 0, 0, 0);
		send_level_op(OP_REM_RNG, 0, 1, 127, 0);
		send_level_op(OP_REM_RNG, 0, 0, 2, 0);
		send_level_op(OP_CLEAR, 0, 0, 0, 0);
		send_level_op(OP_SPACING, 0, 0, 0, 0);
		for (int k = 0; k < 64; k++)
			send_level_op(OP_INSERT, 31'(k * 1000), 0, 0, 0);
		send_level_op(OP_INSERT, -5, 0, 0, 1);
		send_level_op(OP_READ, 0, 63, 0, 0);
		send_level_op(OP_GAP, 0, 64, 0, 0);
		send_level_op(OP_SPACING, 0, 0, 0, 0);
		set_limits(500, 0);
		send_level_op(OP_REM_VAL, 1000, 0, 0, 0);
		send_level_op(OP_CLEAR, 0, 0, 0, 0);

		// Random part, in phases of differing separation and tolerance.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_limits(500, 1);
				1: set_limits(0, 0);
				2: set_limits(131071, 1023);
				3: set_limits(100000, 1000);
				4: set_limits($urandom_range(0, 131071), $urandom_range(0, 1023));
				default: set_limits(1, 2);
			endcase
			for (int n = 0; n < 160; n++) begin
				if (phase == 2 && n == 80)
					drain_results();
				send_random_op();
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d items and checked %0d results over six register settings,",
			items_sent, checked);
		$display("separation 0 to 131071 mm and tolerance 0 to 1023 mm.");
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
